// ===== src/iasp_pkg.sv =====
// shared types, constants and register codes for the inverter auto-switch policy
package iasp_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;

    localparam int POWER_W  = 21;
    localparam int CHARGE_W = 22;
    localparam int LOAD_W   = 21;
    localparam int VOLT_W   = 16;
    localparam int PERIOD_W = 10;
    localparam int COUNT_W  = 28;

    localparam logic [COUNT_W-1:0]  COUNT_LAST   = 28'hFFFFFFE;
    localparam logic [PERIOD_W-1:0] OFF_HOLD_RST = 10'd500;
    localparam logic [CHARGE_W-1:0] SOLAR_RST    = 22'd15000;
    localparam logic [LOAD_W-1:0]   LOAD_TH_RST  = 21'd3300;
    localparam logic [VOLT_W-1:0]   VOLT_TH_RST  = 16'd1400;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        REG_OFF_HOLD = 2'd0,
        REG_SOLAR    = 2'd1,
        REG_LOAD     = 2'd2,
        REG_VOLT     = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [POWER_W-1:0] charge_power_a;
        logic [POWER_W-1:0] charge_power_b;
        logic [POWER_W-1:0] discharge_power_a;
        logic [POWER_W-1:0] discharge_power_b;
        logic [POWER_W-1:0] load_power;
        logic [VOLT_W-1:0]  battery_voltage;
        logic               inverter_on;
        logic               user_press;
    } sample_t;

    typedef struct packed {
        logic                inverter_command;
        logic [CHARGE_W-1:0] avg_charge;
        logic [CHARGE_W-1:0] avg_discharge;
        logic [LOAD_W-1:0]   avg_load;
    } result_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] off_hold_period;
        logic [CHARGE_W-1:0] solar_threshold;
        logic [LOAD_W-1:0]   load_threshold;
        logic [VOLT_W-1:0]   voltage_threshold;
    } cfg_t;

    typedef struct packed {
        logic [CHARGE_W-1:0] charge;
        logic [CHARGE_W-1:0] discharge;
        logic [LOAD_W-1:0]   load;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic div_start;
        logic decide;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

endpackage

// ===== src/iasp_if.sv =====
// valid/ready channel interfaces for samples and results
interface iasp_sample_if;
    logic                         valid;
    logic                         ready;
    logic [iasp_pkg::POWER_W-1:0] charge_power_a;
    logic [iasp_pkg::POWER_W-1:0] charge_power_b;
    logic [iasp_pkg::POWER_W-1:0] discharge_power_a;
    logic [iasp_pkg::POWER_W-1:0] discharge_power_b;
    logic [iasp_pkg::POWER_W-1:0] load_power;
    logic [iasp_pkg::VOLT_W-1:0]  battery_voltage;
    logic                         inverter_on;
    logic                         user_press;

    modport source (
        output valid, charge_power_a, charge_power_b, discharge_power_a,
               discharge_power_b, load_power, battery_voltage, inverter_on, user_press,
        input  ready
    );
    modport sink (
        input  valid, charge_power_a, charge_power_b, discharge_power_a,
               discharge_power_b, load_power, battery_voltage, inverter_on, user_press,
        output ready
    );
endinterface

interface iasp_result_if;
    logic                          valid;
    logic                          ready;
    logic                          inverter_command;
    logic [iasp_pkg::CHARGE_W-1:0] avg_charge;
    logic [iasp_pkg::CHARGE_W-1:0] avg_discharge;
    logic [iasp_pkg::LOAD_W-1:0]   avg_load;

    modport source (
        output valid, inverter_command, avg_charge, avg_discharge, avg_load,
        input  ready
    );
    modport sink (
        input  valid, inverter_command, avg_charge, avg_discharge, avg_load,
        output ready
    );
endinterface

// ===== src/inverter_auto_switch_policy.sv =====
// top level: inverter auto-switch policy with windowed power averages
//
// samples (valid/ready sink) carries one power sample per word; results
// (valid/ready source) returns exactly one word per sample: the inverter
// command and the windowed charge, discharge and load averages.
// configuration sits behind an apb port, one 32-bit register every 4 bytes:
// off_hold_period, solar_threshold, load_threshold, voltage_threshold.
// a sample passes capture, window update, divider start, the divider pass and
// the decision before its result is valid; the shared four-lane bit-serial
// divider forms the averages and the recheck phase over DIV_W bits, where
// DIV_W is the wider of 28 and the charge sum width (22 + log2 window depth).
// one sample is in work at a time, so a new sample is not taken until the
// result word of the previous one is loaded; ready rises again the cycle after
// that load, even if the word has not yet been taken.
// if the receiver stalls, the finished word holds in the output register and
// the next sample stops just before its result would be loaded.
// reset clears the window and sums, presets the counters, turns the command on and
// restores the register defaults; no clearing pass is needed.
module inverter_auto_switch_policy #(
    parameter int WINDOW_DEPTH = iasp_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    iasp_sample_if.sink                   samples,
    iasp_result_if.source                 results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iasp_pkg::APB_AW-1:0]   paddr,
    input  logic [iasp_pkg::APB_DW-1:0]   pwdata,
    output logic [iasp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    iasp_pkg::cfg_t        cfg_reg;
    iasp_pkg::reg_index_t  reg_sel;
    iasp_pkg::ctrl_cmd_t   cmd;
    iasp_pkg::dp_status_t  status;
    iasp_pkg::sample_t     smp;
    iasp_pkg::result_t     res;
    logic                  cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = iasp_pkg::reg_index_t'(paddr[iasp_pkg::APB_AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.off_hold_period   <= iasp_pkg::OFF_HOLD_RST;
            cfg_reg.solar_threshold   <= iasp_pkg::SOLAR_RST;
            cfg_reg.load_threshold    <= iasp_pkg::LOAD_TH_RST;
            cfg_reg.voltage_threshold <= iasp_pkg::VOLT_TH_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                iasp_pkg::REG_OFF_HOLD:
                    cfg_reg.off_hold_period   <= pwdata[iasp_pkg::PERIOD_W-1:0];
                iasp_pkg::REG_SOLAR:
                    cfg_reg.solar_threshold   <= pwdata[iasp_pkg::CHARGE_W-1:0];
                iasp_pkg::REG_LOAD:
                    cfg_reg.load_threshold    <= pwdata[iasp_pkg::LOAD_W-1:0];
                iasp_pkg::REG_VOLT:
                    cfg_reg.voltage_threshold <= pwdata[iasp_pkg::VOLT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            iasp_pkg::REG_OFF_HOLD: prdata = iasp_pkg::APB_DW'(cfg_reg.off_hold_period);
            iasp_pkg::REG_SOLAR:    prdata = iasp_pkg::APB_DW'(cfg_reg.solar_threshold);
            iasp_pkg::REG_LOAD:     prdata = iasp_pkg::APB_DW'(cfg_reg.load_threshold);
            iasp_pkg::REG_VOLT:     prdata = iasp_pkg::APB_DW'(cfg_reg.voltage_threshold);
            default:                prdata = '0;
        endcase
    end

    always_comb
    begin
        smp.charge_power_a    = samples.charge_power_a;
        smp.charge_power_b    = samples.charge_power_b;
        smp.discharge_power_a = samples.discharge_power_a;
        smp.discharge_power_b = samples.discharge_power_b;
        smp.load_power        = samples.load_power;
        smp.battery_voltage   = samples.battery_voltage;
        smp.inverter_on       = samples.inverter_on;
        smp.user_press        = samples.user_press;
    end

    assign results.inverter_command = res.inverter_command;
    assign results.avg_charge       = res.avg_charge;
    assign results.avg_discharge    = res.avg_discharge;
    assign results.avg_load         = res.avg_load;

    iasp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (samples.valid),
        .sample_ready (samples.ready),
        .result_valid (results.valid),
        .result_ready (results.ready),
        .status       (status),
        .cmd          (cmd)
    );

    iasp_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .cfg    (cfg_reg),
        .smp    (smp),
        .res    (res)
    );

endmodule

// ===== src/iasp_div.sv =====
// multi-lane restoring divider, one quotient bit per lane per cycle
module iasp_div #(
    parameter int DIV_W = 28,
    parameter int VW    = 10,
    parameter int LANES = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend  [LANES],
    input  logic [VW-1:0]    divisor   [LANES],
    output logic             done,
    output logic [DIV_W-1:0] quotient  [LANES],
    output logic [VW-1:0]    remainder [LANES]
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg  [LANES];
    logic [DIV_W-1:0] quo_next [LANES];
    logic [VW-1:0]    rem_reg  [LANES];
    logic [VW-1:0]    rem_next [LANES];
    logic [VW-1:0]    dvs_reg  [LANES];
    logic [VW:0]      trial    [LANES];
    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            trial[l] = {rem_reg[l], quo_reg[l][DIV_W-1]};
            if (trial[l] >= {1'b0, dvs_reg[l]})
            begin
                rem_next[l] = VW'(trial[l] - {1'b0, dvs_reg[l]});
                quo_next[l] = {quo_reg[l][DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[l] = trial[l][VW-1:0];
                quo_next[l] = {quo_reg[l][DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            dvs_reg <= divisor;
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[l] <= '0;
            end
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (start)
        begin
            count_reg <= CNT_W'(DIV_W);
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/iasp_datapath.sv =====
// sample window memory, running sums, divider lanes and switch policy registers
module iasp_datapath #(
    parameter int WINDOW_DEPTH = iasp_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  iasp_pkg::ctrl_cmd_t    cmd,
    output iasp_pkg::dp_status_t   status,
    input  iasp_pkg::cfg_t         cfg,
    input  iasp_pkg::sample_t      smp,
    output iasp_pkg::result_t      res
);

    localparam int SLOT_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int GROW_W   = $clog2(WINDOW_DEPTH);
    localparam int CSUM_W   = iasp_pkg::CHARGE_W + GROW_W;
    localparam int LSUM_W   = iasp_pkg::LOAD_W + GROW_W;
    localparam int HELD_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int PERIOD_W = iasp_pkg::PERIOD_W;
    localparam int COUNT_W  = iasp_pkg::COUNT_W;
    localparam int DIV_W    = (CSUM_W > COUNT_W) ? CSUM_W : COUNT_W;
    localparam int LANES    = 4;
    localparam int LANE_CHARGE    = 0;
    localparam int LANE_DISCHARGE = 1;
    localparam int LANE_LOAD      = 2;
    localparam int LANE_COUNT     = 3;

    localparam logic [SLOT_W-1:0]   SLOT_RST   = SLOT_W'(1 % WINDOW_DEPTH);
    localparam logic [SLOT_W-1:0]   SLOT_LAST  = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [HELD_W-1:0]   HELD_FULL  = HELD_W'(WINDOW_DEPTH);
    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(2 * WINDOW_DEPTH);

    iasp_pkg::entry_t  mem [WINDOW_DEPTH];
    iasp_pkg::entry_t  rd_entry_reg;
    iasp_pkg::entry_t  old_entry;
    iasp_pkg::entry_t  new_entry;
    iasp_pkg::sample_t smp_reg;
    iasp_pkg::result_t res_reg;

    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic                    rd_valid_reg;
    logic [CSUM_W-1:0]       charge_sum_reg;
    logic [CSUM_W-1:0]       charge_sum_next;
    logic [CSUM_W-1:0]       discharge_sum_reg;
    logic [CSUM_W-1:0]       discharge_sum_next;
    logic [LSUM_W-1:0]       load_sum_reg;
    logic [LSUM_W-1:0]       load_sum_next;
    logic [HELD_W-1:0]       held_reg;
    logic [COUNT_W-1:0]      counter_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [PERIOD_W-1:0]     period_reg;
    logic                    command_reg;

    logic [DIV_W-1:0]    dividend  [LANES];
    logic [PERIOD_W-1:0] divisor   [LANES];
    logic [DIV_W-1:0]    quotient  [LANES];
    logic [PERIOD_W-1:0] remainder [LANES];
    logic                div_done;

    logic [iasp_pkg::CHARGE_W-1:0] avg_c;
    logic [iasp_pkg::CHARGE_W-1:0] avg_d;
    logic [iasp_pkg::LOAD_W-1:0]   avg_l;
    logic                          recheck;
    logic                          all_low;
    logic                          command_dec;
    logic [PERIOD_W-1:0]           period_dec;

    // window update
    always_comb
    begin
        old_entry           = rd_valid_reg ? rd_entry_reg : '0;
        new_entry.charge    = iasp_pkg::CHARGE_W'(smp_reg.charge_power_a)
                            + iasp_pkg::CHARGE_W'(smp_reg.charge_power_b);
        new_entry.discharge = iasp_pkg::CHARGE_W'(smp_reg.discharge_power_a)
                            + iasp_pkg::CHARGE_W'(smp_reg.discharge_power_b);
        new_entry.load      = smp_reg.load_power;
        charge_sum_next     = charge_sum_reg - CSUM_W'(old_entry.charge)
                            + CSUM_W'(new_entry.charge);
        discharge_sum_next  = discharge_sum_reg - CSUM_W'(old_entry.discharge)
                            + CSUM_W'(new_entry.discharge);
        load_sum_next       = load_sum_reg - LSUM_W'(old_entry.load)
                            + LSUM_W'(new_entry.load);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            smp_reg      <= smp;
            rd_entry_reg <= mem[slot_reg];
        end
        if (cmd.update)
        begin
            mem[slot_reg] <= new_entry;
        end
    end

    // divider lanes: three averages share the held count, the fourth finds the recheck phase
    always_comb
    begin
        dividend[LANE_CHARGE]    = DIV_W'(charge_sum_reg);
        dividend[LANE_DISCHARGE] = DIV_W'(discharge_sum_reg);
        dividend[LANE_LOAD]      = DIV_W'(load_sum_reg);
        dividend[LANE_COUNT]     = DIV_W'(counter_reg);
        divisor[LANE_CHARGE]     = PERIOD_W'(held_reg);
        divisor[LANE_DISCHARGE]  = PERIOD_W'(held_reg);
        divisor[LANE_LOAD]       = PERIOD_W'(held_reg);
        divisor[LANE_COUNT]      = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    end

    iasp_div #(
        .DIV_W (DIV_W),
        .VW    (PERIOD_W),
        .LANES (LANES)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (divisor),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign status.div_done = div_done;

    // switch policy
    always_comb
    begin
        avg_c   = quotient[LANE_CHARGE][iasp_pkg::CHARGE_W-1:0];
        avg_d   = quotient[LANE_DISCHARGE][iasp_pkg::CHARGE_W-1:0];
        avg_l   = quotient[LANE_LOAD][iasp_pkg::LOAD_W-1:0];
        recheck = (remainder[LANE_COUNT] == '0);
        all_low = (avg_c < cfg.solar_threshold) && (avg_l < cfg.load_threshold)
               && (smp_reg.battery_voltage < cfg.voltage_threshold);
        command_dec = command_reg;
        period_dec  = period_reg;
        if (recheck)
        begin
            if (!smp_reg.inverter_on)
            begin
                command_dec = 1'b1;
                period_dec  = PERIOD_RST;
            end
            else if (all_low)
            begin
                command_dec = 1'b0;
                period_dec  = cfg.off_hold_period;
            end
            else
            begin
                command_dec = 1'b1;
                period_dec  = PERIOD_RST;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg         <= '0;
            rd_valid_reg      <= 1'b0;
            charge_sum_reg    <= '0;
            discharge_sum_reg <= '0;
            load_sum_reg      <= '0;
            held_reg          <= '0;
            counter_reg       <= COUNT_W'(1);
            slot_reg          <= SLOT_RST;
            period_reg        <= PERIOD_RST;
            command_reg       <= 1'b1;
        end
        else
        begin
            if (cmd.capture)
            begin
                rd_valid_reg <= valid_reg[slot_reg];
            end
            if (cmd.update)
            begin
                valid_reg[slot_reg] <= 1'b1;
                charge_sum_reg      <= charge_sum_next;
                discharge_sum_reg   <= discharge_sum_next;
                load_sum_reg        <= load_sum_next;
                if (held_reg != HELD_FULL)
                begin
                    held_reg <= held_reg + 1'b1;
                end
                // user toggle, turning off arms the long hold
                if (smp_reg.user_press)
                begin
                    command_reg <= !command_reg;
                    if (command_reg)
                    begin
                        period_reg <= cfg.off_hold_period;
                    end
                end
            end
            else if (cmd.decide)
            begin
                command_reg <= command_dec;
                period_reg  <= period_dec;
                if (counter_reg == iasp_pkg::COUNT_LAST)
                begin
                    counter_reg <= '0;
                    slot_reg    <= '0;
                end
                else
                begin
                    counter_reg <= counter_reg + 1'b1;
                    slot_reg    <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            res_reg.inverter_command <= command_dec;
            res_reg.avg_charge       <= avg_c;
            res_reg.avg_discharge    <= avg_d;
            res_reg.avg_load         <= avg_l;
        end
    end

    assign res = res_reg;

endmodule

// ===== src/iasp_ctrl.sv =====
// sequencing state machine and result word valid flag
module iasp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    output logic                 result_valid,
    input  logic                 result_ready,
    input  iasp_pkg::dp_status_t status,
    output iasp_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FETCH  = 5'b00010,
        ST_START  = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_DECIDE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        sample_ready   = 1'b0;
        out_valid_next = out_valid_reg && !result_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.update = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // hold here while the previous word still waits
                if (out_free)
                begin
                    cmd.decide     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// ===== src/iasp_checker.sv =====
// port-level checker for the inverter auto-switch policy, bound to the top level
module iasp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          r_valid,
    input logic                          r_ready,
    input logic                          r_command,
    input logic [iasp_pkg::CHARGE_W-1:0] r_avg_charge,
    input logic [iasp_pkg::CHARGE_W-1:0] r_avg_discharge,
    input logic [iasp_pkg::LOAD_W-1:0]   r_avg_load
);

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_command) && $stable(r_avg_charge)
            && $stable(r_avg_discharge) && $stable(r_avg_load))
        else $error("result word changed while stalled");

    // one sample in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid && s_ready |=> !s_ready)
        else $error("sample accepted while another is in work");

    // the input does not reopen early, before the averages could be formed
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid && s_ready |=> ##2 !s_ready)
        else $error("input reopened before the averages could be formed");

    // a busy block with a stalled result cannot reopen its input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready && !s_ready |=> !s_ready)
        else $error("input reopened while the previous result is stalled");

endmodule

bind inverter_auto_switch_policy iasp_checker u_iasp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .s_valid         (samples.valid),
    .s_ready         (samples.ready),
    .r_valid         (results.valid),
    .r_ready         (results.ready),
    .r_command       (results.inverter_command),
    .r_avg_charge    (results.avg_charge),
    .r_avg_discharge (results.avg_discharge),
    .r_avg_load      (results.avg_load)
);

// ===== dv/inverter_auto_switch_policy_test.sv =====
// self-checking testbench for the inverter auto-switch policy block
`timescale 1ns / 100ps

module inverter_auto_switch_policy_test;

    localparam int DEPTH         = iasp_pkg::WINDOW_DEPTH_DEF;
    localparam int CSUM_W        = iasp_pkg::CHARGE_W + $clog2(DEPTH);
    localparam int LSUM_W        = iasp_pkg::LOAD_W + $clog2(DEPTH);
    localparam int PHASE_ITEMS   = 240;
    localparam int PHASES        = 5;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_AT       = 800;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [iasp_pkg::PERIOD_W-1:0] RECHECK_RST = iasp_pkg::PERIOD_W'(2 * DEPTH);
    localparam int unsigned PMAX = (1 << iasp_pkg::POWER_W) - 1;

    typedef struct {
        iasp_pkg::sample_t word;
        bit                typed;
        iasp_pkg::result_t want;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [iasp_pkg::APB_AW-1:0] paddr;
    logic [iasp_pkg::APB_DW-1:0] pwdata;
    logic [iasp_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    iasp_sample_if sample_ch();
    iasp_result_if result_ch();

    inverter_auto_switch_policy u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // policy state mirrored from the block
    iasp_pkg::cfg_t                policy_cfg;
    logic [iasp_pkg::CHARGE_W-1:0] charge_ring    [DEPTH];
    logic [iasp_pkg::CHARGE_W-1:0] discharge_ring [DEPTH];
    logic [iasp_pkg::LOAD_W-1:0]   load_ring      [DEPTH];
    logic [CSUM_W-1:0]             charge_total;
    logic [CSUM_W-1:0]             discharge_total;
    logic [LSUM_W-1:0]             load_total;
    logic [iasp_pkg::COUNT_W-1:0]  sample_count;
    logic [iasp_pkg::PERIOD_W-1:0] recheck_period;
    logic                          command_on;
    int unsigned                   samples_held;

    iasp_pkg::result_t pending_results [$];
    int unsigned       mismatch_count = 0;
    int unsigned       results_taken  = 0;
    bit                no_gaps        = 1'b0;
    bit                quiet          = 1'b0;
    bit                hold_done      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("inverter_auto_switch_policy_test: errors");
        $finish;
    end

    function automatic void report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function automatic iasp_pkg::result_t predict_policy_step(iasp_pkg::sample_t s);
        iasp_pkg::result_t             r;
        int unsigned                   slot;
        logic [iasp_pkg::CHARGE_W-1:0] c_new;
        logic [iasp_pkg::CHARGE_W-1:0] d_new;
        logic [iasp_pkg::PERIOD_W-1:0] period;
        c_new = iasp_pkg::CHARGE_W'(s.charge_power_a) + iasp_pkg::CHARGE_W'(s.charge_power_b);
        d_new = iasp_pkg::CHARGE_W'(s.discharge_power_a)
              + iasp_pkg::CHARGE_W'(s.discharge_power_b);

        if (s.user_press)
        begin
            if (!command_on)
                command_on = 1'b1;
            else
            begin
                command_on     = 1'b0;
                recheck_period = policy_cfg.off_hold_period;
            end
        end

        slot = sample_count % DEPTH;
        charge_total    = charge_total - CSUM_W'(charge_ring[slot]) + CSUM_W'(c_new);
        discharge_total = discharge_total - CSUM_W'(discharge_ring[slot]) + CSUM_W'(d_new);
        load_total      = load_total - LSUM_W'(load_ring[slot]) + LSUM_W'(s.load_power);
        charge_ring[slot]    = c_new;
        discharge_ring[slot] = d_new;
        load_ring[slot]      = s.load_power;
        if (samples_held < DEPTH)
            samples_held++;

        r.avg_charge    = iasp_pkg::CHARGE_W'(charge_total / samples_held);
        r.avg_discharge = iasp_pkg::CHARGE_W'(discharge_total / samples_held);
        r.avg_load      = iasp_pkg::LOAD_W'(load_total / samples_held);

        // a zero period means recheck on every sample
        period = (recheck_period == '0) ? iasp_pkg::PERIOD_W'(1) : recheck_period;
        if (sample_count % period == 0)
        begin
            if (!s.inverter_on)
            begin
                command_on     = 1'b1;
                recheck_period = RECHECK_RST;
            end
            else if (r.avg_charge < policy_cfg.solar_threshold &&
                     r.avg_load < policy_cfg.load_threshold &&
                     s.battery_voltage < policy_cfg.voltage_threshold)
            begin
                command_on     = 1'b0;
                recheck_period = policy_cfg.off_hold_period;
            end
            else
            begin
                command_on     = s.inverter_on;
                recheck_period = RECHECK_RST;
            end
        end

        sample_count = (sample_count == iasp_pkg::COUNT_LAST) ? '0 : sample_count + 1'b1;
        r.inverter_command = command_on;
        return r;
    endfunction

    function automatic iasp_pkg::sample_t pack_sample(int unsigned ca, int unsigned cb,
                                                      int unsigned da, int unsigned db,
                                                      int unsigned lp, int unsigned volt,
                                                      bit inv, bit press);
        iasp_pkg::sample_t s;
        s.charge_power_a    = iasp_pkg::POWER_W'(ca);
        s.charge_power_b    = iasp_pkg::POWER_W'(cb);
        s.discharge_power_a = iasp_pkg::POWER_W'(da);
        s.discharge_power_b = iasp_pkg::POWER_W'(db);
        s.load_power        = iasp_pkg::POWER_W'(lp);
        s.battery_voltage   = iasp_pkg::VOLT_W'(volt);
        s.inverter_on       = inv;
        s.user_press        = press;
        return s;
    endfunction

    // quiet stretches keep values at or under the thresholds, bar rare charge spikes, so the window average can drop
    function automatic iasp_pkg::sample_t random_sample();
        iasp_pkg::sample_t s;
        int unsigned       c_lim;
        int unsigned       l_lim;
        int unsigned       v_lim;
        if ($urandom_range(0, 39) == 0)
            quiet = !quiet;
        c_lim = quiet ? policy_cfg.solar_threshold / 2 : PMAX;
        l_lim = quiet ? policy_cfg.load_threshold : PMAX;
        v_lim = quiet ? policy_cfg.voltage_threshold : 16'hFFFF;
        if ($urandom_range(0, 19) == 0)
            c_lim = PMAX;
        s.charge_power_a    = iasp_pkg::POWER_W'($urandom_range(0, c_lim));
        s.charge_power_b    = iasp_pkg::POWER_W'($urandom_range(0, c_lim));
        s.discharge_power_a = iasp_pkg::POWER_W'($urandom_range(0, PMAX));
        s.discharge_power_b = iasp_pkg::POWER_W'($urandom_range(0, PMAX));
        s.load_power        = iasp_pkg::POWER_W'($urandom_range(0, l_lim));
        s.battery_voltage   = iasp_pkg::VOLT_W'($urandom_range(0, v_lim));
        // readback mostly follows the command, sometimes disagrees
        s.inverter_on = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : command_on;
        s.user_press  = ($urandom_range(0, 11) == 0);
        return s;
    endfunction

    task automatic program_registers(input logic [iasp_pkg::APB_DW-1:0] vals [4]);
        iasp_pkg::reg_index_t        idx;
        logic [iasp_pkg::APB_DW-1:0] readback;
        for (int i = 0; i < 4; i++)
        begin
            idx = iasp_pkg::reg_index_t'(i);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= vals[i];
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (pready !== 1'b1);
            case (idx)
                iasp_pkg::REG_OFF_HOLD:
                begin
                    policy_cfg.off_hold_period = vals[i][iasp_pkg::PERIOD_W-1:0];
                    readback = iasp_pkg::APB_DW'(policy_cfg.off_hold_period);
                end
                iasp_pkg::REG_SOLAR:
                begin
                    policy_cfg.solar_threshold = vals[i][iasp_pkg::CHARGE_W-1:0];
                    readback = iasp_pkg::APB_DW'(policy_cfg.solar_threshold);
                end
                iasp_pkg::REG_LOAD:
                begin
                    policy_cfg.load_threshold = vals[i][iasp_pkg::LOAD_W-1:0];
                    readback = iasp_pkg::APB_DW'(policy_cfg.load_threshold);
                end
                default:
                begin
                    policy_cfg.voltage_threshold = vals[i][iasp_pkg::VOLT_W-1:0];
                    readback = iasp_pkg::APB_DW'(policy_cfg.voltage_threshold);
                end
            endcase
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (pready !== 1'b1);
            if (prdata !== readback)
                report_mismatch($sformatf("register %s read expected %0d got %0d",
                                          idx.name(), readback, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_sample(input iasp_pkg::sample_t s, input bit typed,
                               input iasp_pkg::result_t want);
        iasp_pkg::result_t predicted;
        while (!no_gaps && $urandom_range(0, 99) < 36)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid             <= 1'b1;
        sample_ch.charge_power_a    <= s.charge_power_a;
        sample_ch.charge_power_b    <= s.charge_power_b;
        sample_ch.discharge_power_a <= s.discharge_power_a;
        sample_ch.discharge_power_b <= s.discharge_power_b;
        sample_ch.load_power        <= s.load_power;
        sample_ch.battery_voltage   <= s.battery_voltage;
        sample_ch.inverter_on       <= s.inverter_on;
        sample_ch.user_press        <= s.user_press;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        predicted = predict_policy_step(s);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: random stalls, one long hold-off, compare against the oldest prediction
    initial
    begin
        iasp_pkg::result_t want;
        iasp_pkg::result_t got;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                results_taken++;
                got = '{result_ch.inverter_command, result_ch.avg_charge,
                        result_ch.avg_discharge, result_ch.avg_load};
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("word %0d arrived with nothing pending",
                                              results_taken));
                else
                begin
                    want = pending_results.pop_front();
                    if (got.inverter_command !== want.inverter_command)
                        report_mismatch($sformatf("word %0d inverter_command expected %0d got %0d",
                                                  results_taken, want.inverter_command,
                                                  got.inverter_command));
                    if (got.avg_charge !== want.avg_charge)
                        report_mismatch($sformatf("word %0d avg_charge expected %0d got %0d",
                                                  results_taken, want.avg_charge, got.avg_charge));
                    if (got.avg_discharge !== want.avg_discharge)
                        report_mismatch($sformatf("word %0d avg_discharge expected %0d got %0d",
                                                  results_taken, want.avg_discharge,
                                                  got.avg_discharge));
                    if (got.avg_load !== want.avg_load)
                        report_mismatch($sformatf("word %0d avg_load expected %0d got %0d",
                                                  results_taken, want.avg_load, got.avg_load));
                end
            end
            if (!hold_done && results_taken == HOLD_AT)
            begin
                hold_done = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                result_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 36);
        end
    end

    initial
    begin
        stim_row_t                   dir_rows [$];
        logic [iasp_pkg::APB_DW-1:0] regs [4];

        rst_n                       <= 1'b0;
        psel                        <= 1'b0;
        penable                     <= 1'b0;
        pwrite                      <= 1'b0;
        paddr                       <= '0;
        pwdata                      <= '0;
        sample_ch.valid             <= 1'b0;
        sample_ch.charge_power_a    <= '0;
        sample_ch.charge_power_b    <= '0;
        sample_ch.discharge_power_a <= '0;
        sample_ch.discharge_power_b <= '0;
        sample_ch.load_power        <= '0;
        sample_ch.battery_voltage   <= '0;
        sample_ch.inverter_on       <= 1'b0;
        sample_ch.user_press        <= 1'b0;

        policy_cfg = '{iasp_pkg::OFF_HOLD_RST, iasp_pkg::SOLAR_RST,
                       iasp_pkg::LOAD_TH_RST, iasp_pkg::VOLT_TH_RST};
        for (int i = 0; i < DEPTH; i++)
        begin
            charge_ring[i]    = '0;
            discharge_ring[i] = '0;
            load_ring[i]      = '0;
        end
        charge_total    = '0;
        discharge_total = '0;
        load_total      = '0;
        sample_count    = iasp_pkg::COUNT_W'(1);
        recheck_period  = RECHECK_RST;
        command_on      = 1'b1;
        samples_held    = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero hold period: once switched off, policy runs on every sample; voltage decides switch off
        regs = '{32'd0, 32'd4194303, 32'd2097151, 32'd1400};
        program_registers(regs);

        dir_rows.push_back('{pack_sample(0, 0, 0, 0, 0, 0, 1, 0), 1'b1,
                             '{1'b1, 22'd0, 22'd0, 21'd0}});
        dir_rows.push_back('{pack_sample(PMAX, PMAX, PMAX, PMAX, PMAX, 16'hFFFF, 1, 0), 1'b1,
                             '{1'b1, 22'd2097151, 22'd2097151, 21'd1048575}});
        dir_rows.push_back('{pack_sample(100, 50, 7, 3, 40, 1000, 1, 1), 1'b0, '0});
        dir_rows.push_back('{pack_sample(21'h155555, 21'h0AAAAA, 21'h155555, 21'h0AAAAA,
                                         21'h155555, 16'h5555, 0, 0), 1'b0, '0});
        dir_rows.push_back('{pack_sample(21'h0AAAAA, 21'h155555, 21'h0AAAAA, 21'h155555,
                                         21'h0AAAAA, 16'hAAAA, 1, 1), 1'b0, '0});
        dir_rows.push_back('{pack_sample(1, 2, 3, 4, 5, 1399, 1, 1), 1'b0, '0});
        dir_rows.push_back('{pack_sample(0, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0});
        dir_rows.push_back('{pack_sample(6, 7, 8, 9, 10, 1400, 1, 1), 1'b0, '0});
        dir_rows.push_back('{pack_sample(0, 0, 0, 0, 0, 0, 1, 1), 1'b0, '0});
        dir_rows.push_back('{pack_sample(PMAX, 0, PMAX, 0, PMAX, 0, 1, 0), 1'b0, '0});
        dir_rows.push_back('{pack_sample(0, PMAX, 0, PMAX, 0, 16'hFFFF, 0, 0), 1'b0, '0});
        dir_rows.push_back('{pack_sample(PMAX, PMAX, PMAX, PMAX, PMAX, 0, 1, 1), 1'b0, '0});
        dir_rows.push_back('{pack_sample(0, 0, 0, 0, 0, 16'hFFFF, 1, 0), 1'b0, '0});
        dir_rows.push_back('{pack_sample(21'h1FFFFE, 1, 21'h100000, 21'h0FFFFF, PMAX,
                                         16'h8000, 1, 1), 1'b0, '0});
        dir_rows.push_back('{pack_sample(1, 21'h1FFFFE, 21'h0FFFFF, 21'h100000, 1,
                                         16'h7FFF, 0, 1), 1'b0, '0});

        foreach (dir_rows[i])
            send_sample(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
        sample_ch.valid <= 1'b0;
        drain_results();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: regs = '{32'd1, 32'd4194303, 32'd2097151, 32'd65535};
                1: regs = '{32'd1023, 32'd0, 32'd0, 32'd0};
                2: regs = '{32'd32, 32'd15000, 32'd3300, 32'd1400};
                3: regs = '{32'($urandom_range(1, 1023)), 32'($urandom_range(0, 4194303)),
                            32'($urandom_range(0, 2097151)), 32'($urandom_range(0, 65535))};
                default: regs = '{32'd3, 32'd400000, 32'd150000, 32'd12000};
            endcase
            program_registers(regs);
            no_gaps = (phase == 2);
            repeat (PHASE_ITEMS)
                send_sample(random_sample(), 1'b0, '0);
            sample_ch.valid <= 1'b0;
            drain_results();
            no_gaps = 1'b0;
        end

        if (mismatch_count == 0)
            $display("inverter_auto_switch_policy_test: clean");
        else
            $display("inverter_auto_switch_policy_test: errors");
        $finish;
    end

endmodule
